// ----- sv/mrfs_pkg.sv -----
// Package with types, sizes and codes of the maximal-rectangles free-space store.
package mrfs_pkg;

  localparam int unsigned MaxFree   = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned ScrDepth  = 4 * MaxFree;
  localparam int unsigned CntW      = $clog2(MaxFree + 1);
  localparam int unsigned IdxW      = $clog2(MaxFree);
  localparam int unsigned ScrIdxW   = $clog2(ScrDepth);
  localparam int unsigned ScrCntW   = $clog2(ScrDepth + 1);
  localparam int unsigned AreaW     = 2 * CoordBits;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAdd    = 2'd1,
    CmdOccupy = 2'd2,
    CmdFind   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] w;
    logic [CoordBits-1:0] h;
  } box_t;

  typedef struct packed {
    box_t             box;
    logic [AreaW-1:0] area;
  } scr_t;

  typedef enum logic [4:0] {
    StIdle,
    StFdRd, StFdCk,
    StAmRd, StAmCk, StAmDec,
    StAsRd, StAsWr,
    StOcRd, StOcLd, StOcPc,
    StSoStart, StSoI, StSoT, StSoK, StSoC,
    StPrStart, StPrI, StPrT, StPrK, StPrC,
    StDone
  } state_e;

endpackage

// ----- sv/maxrects_free_space_store.sv -----
// Top level of the maximal-rectangles free-space store with its command sequencer.
//
// One input item carries a command (clear, add free rectangle, occupy box,
// find best fit) and a rectangle. Both channels use valid and ready; an item
// is accepted when valid and ready are high at a rising clock edge.
// The block takes one item at a time: in_ready_o is high only while the
// sequencer is idle. Every command gives exactly one result item.
// Clear and a non-full add go straight to the result. Find reads every held
// rectangle in turn. An add into a full list scans all 64 entries and may
// shift the tail. Occupy is the longest: it splits the list into up to 256
// pieces, insertion-sorts them in the scratch memory and prunes contained
// pieces against the new list. The single read port of each memory and the
// shared multiplier make each of these steps run one entry at a time.
// A finished result waits in the output register; when the receiver stalls,
// the sequencer holds its result until the output register is free.
// Reset empties the list and clears the result valid; the memories are not
// cleared, since only entries below the count are ever read.
module maxrects_free_space_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] rect_x_i,
  input  logic [15:0] rect_y_i,
  input  logic [15:0] rect_width_i,
  input  logic [15:0] rect_height_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [15:0] place_x_o,
  output logic [15:0] place_y_o,
  output logic [6:0]  free_count_o,
  output logic        overflow_o
);

  localparam int unsigned CW = mrfs_pkg::CoordBits;

  mrfs_pkg::state_e state_q, state_d;
  mrfs_pkg::box_t   sbox_q, sbox_d;
  mrfs_pkg::box_t   fbox_q, fbox_d;
  mrfs_pkg::scr_t   t_q, t_d;
  logic [mrfs_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [mrfs_pkg::ScrCntW-1:0] i_q, i_d, k_q, k_d, n_q, n_d;
  logic [mrfs_pkg::IdxW-1:0]    min_idx_q, min_idx_d;
  logic [mrfs_pkg::AreaW-1:0]   min_area_q, min_area_d;
  logic [CW:0]                  best_q, best_d;
  logic [1:0]                   piece_q, piece_d;
  logic                         ovl_q, ovl_d;
  logic                         found_q, found_d, over_q, over_d;
  logic [CW-1:0]                px_q, px_d, py_q, py_d;
  logic                         ov_q, ov_d;
  logic                         of_q, of_d;
  logic [CW-1:0]                opx_q, opx_d, opy_q, opy_d;
  logic [mrfs_pkg::CntW-1:0]    ocnt_q, ocnt_d;
  logic                         oov_q, oov_d;

  mrfs_pkg::box_t fmem [mrfs_pkg::MaxFree];
  mrfs_pkg::box_t frd_q;
  logic                         fwe;
  logic [mrfs_pkg::IdxW-1:0]    fwaddr, fraddr;
  mrfs_pkg::box_t               fwdata;

  mrfs_pkg::scr_t smem [mrfs_pkg::ScrDepth];
  mrfs_pkg::scr_t srd_q;
  logic                         swe;
  logic [mrfs_pkg::ScrIdxW-1:0] swaddr, sraddr;
  mrfs_pkg::scr_t               swdata;

  always_ff @(posedge clk_i) begin
    if (fwe) begin
      fmem[fwaddr] <= fwdata;
    end
    frd_q <= fmem[fraddr];
  end

  always_ff @(posedge clk_i) begin
    if (swe) begin
      smem[swaddr] <= swdata;
    end
    srd_q <= smem[sraddr];
  end

  logic                 fit, ovl, keep_pc, holds;
  logic [CW:0]          waste;
  logic [mrfs_pkg::AreaW-1:0] area_rd, area_new, area_pc;
  logic [CW-1:0]        mul_a, mul_b;
  logic [mrfs_pkg::AreaW-1:0] mul_p;
  logic signed [CW+2:0] pxs, pys, pws, phs;
  logic signed [CW+2:0] fx, fy, fw, fh, sx, sy, sw, sh;

  always_comb begin
    fx = $signed({3'b000, fbox_q.x});
    fy = $signed({3'b000, fbox_q.y});
    fw = $signed({3'b000, fbox_q.w});
    fh = $signed({3'b000, fbox_q.h});
    sx = $signed({3'b000, sbox_q.x});
    sy = $signed({3'b000, sbox_q.y});
    sw = $signed({3'b000, sbox_q.w});
    sh = $signed({3'b000, sbox_q.h});
    pxs = fx;
    pys = fy;
    pws = fw;
    phs = fh;
    if (ovl_q) begin
      unique case (piece_q)
        2'd0: pws = sx - fx;
        2'd1: phs = sy - fy;
        2'd2: begin
          pxs = sx + sw;
          pws = fx + fw - sx - sw;
        end
        default: begin
          pys = sy + sh;
          phs = fy + fh - sy - sh;
        end
      endcase
    end
    keep_pc = (pws > 0) && (phs > 0) &&
              (pxs <= $signed((CW+3)'({CW{1'b1}}))) &&
              (pys <= $signed((CW+3)'({CW{1'b1}}))) &&
              (n_q < (mrfs_pkg::ScrCntW)'(mrfs_pkg::ScrDepth));

    unique case (state_q)
      mrfs_pkg::StOcPc: begin
        mul_a = pws[CW-1:0];
        mul_b = phs[CW-1:0];
      end
      mrfs_pkg::StAmDec: begin
        mul_a = sbox_q.w;
        mul_b = sbox_q.h;
      end
      default: begin
        mul_a = frd_q.w;
        mul_b = frd_q.h;
      end
    endcase
    mul_p    = mul_a * mul_b;
    area_pc  = mul_p;
    area_rd  = mul_p;
    area_new = mul_p;

    ovl = ({1'b0, frd_q.x} < {1'b0, sbox_q.x} + {1'b0, sbox_q.w}) &&
          ({1'b0, sbox_q.x} < {1'b0, frd_q.x} + {1'b0, frd_q.w}) &&
          ({1'b0, frd_q.y} < {1'b0, sbox_q.y} + {1'b0, sbox_q.h}) &&
          ({1'b0, sbox_q.y} < {1'b0, frd_q.y} + {1'b0, frd_q.h});

    fit   = (frd_q.w >= sbox_q.w) && (frd_q.h >= sbox_q.h);
    waste = {1'b0, frd_q.w - sbox_q.w} + {1'b0, frd_q.h - sbox_q.h};

    holds = (frd_q.x <= t_q.box.x) && (frd_q.y <= t_q.box.y) &&
            ({1'b0, t_q.box.x} + {1'b0, t_q.box.w} <= {1'b0, frd_q.x} + {1'b0, frd_q.w}) &&
            ({1'b0, t_q.box.y} + {1'b0, t_q.box.h} <= {1'b0, frd_q.y} + {1'b0, frd_q.h});
  end

  always_comb begin
    state_d    = state_q;
    sbox_d     = sbox_q;
    fbox_d     = fbox_q;
    t_d        = t_q;
    cnt_d      = cnt_q;
    i_d        = i_q;
    k_d        = k_q;
    n_d        = n_q;
    min_idx_d  = min_idx_q;
    min_area_d = min_area_q;
    best_d     = best_q;
    piece_d    = piece_q;
    ovl_d      = ovl_q;
    found_d    = found_q;
    over_d     = over_q;
    px_d       = px_q;
    py_d       = py_q;
    ov_d       = ov_q;
    of_d       = of_q;
    opx_d      = opx_q;
    opy_d      = opy_q;
    ocnt_d     = ocnt_q;
    oov_d      = oov_q;
    fwe        = 1'b0;
    fwaddr     = '0;
    fwdata     = sbox_q;
    fraddr     = '0;
    swe        = 1'b0;
    swaddr     = n_q[mrfs_pkg::ScrIdxW-1:0];
    swdata     = t_q;
    sraddr     = '0;
    in_ready_o = (state_q == mrfs_pkg::StIdle);

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      mrfs_pkg::StIdle: begin
        if (in_valid_i) begin
          sbox_d  = '{x: rect_x_i, y: rect_y_i, w: rect_width_i, h: rect_height_i};
          found_d = 1'b0;
          over_d  = 1'b0;
          px_d    = '0;
          py_d    = '0;
          i_d     = '0;
          n_d     = '0;
          unique case (mrfs_pkg::cmd_e'(cmd_i))
            mrfs_pkg::CmdClear: begin
              cnt_d   = '0;
              state_d = mrfs_pkg::StDone;
            end
            mrfs_pkg::CmdAdd: begin
              if (cnt_q < (mrfs_pkg::CntW)'(mrfs_pkg::MaxFree)) begin
                fwe     = 1'b1;
                fwaddr  = cnt_q[mrfs_pkg::IdxW-1:0];
                fwdata  = '{x: rect_x_i, y: rect_y_i, w: rect_width_i, h: rect_height_i};
                cnt_d   = cnt_q + 1'b1;
                state_d = mrfs_pkg::StDone;
              end else begin
                state_d = mrfs_pkg::StAmRd;
              end
            end
            mrfs_pkg::CmdOccupy: state_d = mrfs_pkg::StOcRd;
            default:             state_d = mrfs_pkg::StFdRd;
          endcase
        end
      end

      mrfs_pkg::StFdRd: begin
        fraddr = i_q[mrfs_pkg::IdxW-1:0];
        if (i_q >= (mrfs_pkg::ScrCntW)'(cnt_q)) begin
          state_d = mrfs_pkg::StDone;
        end else begin
          state_d = mrfs_pkg::StFdCk;
        end
      end
      mrfs_pkg::StFdCk: begin
        if (fit && (!found_q || waste < best_q)) begin
          found_d = 1'b1;
          best_d  = waste;
          px_d    = frd_q.x;
          py_d    = frd_q.y;
        end
        i_d     = i_q + 1'b1;
        state_d = mrfs_pkg::StFdRd;
      end

      mrfs_pkg::StAmRd: begin
        fraddr = i_q[mrfs_pkg::IdxW-1:0];
        if (i_q == (mrfs_pkg::ScrCntW)'(mrfs_pkg::MaxFree)) begin
          state_d = mrfs_pkg::StAmDec;
        end else begin
          state_d = mrfs_pkg::StAmCk;
        end
      end
      mrfs_pkg::StAmCk: begin
        if (i_q == '0 || area_rd < min_area_q) begin
          min_area_d = area_rd;
          min_idx_d  = i_q[mrfs_pkg::IdxW-1:0];
        end
        i_d     = i_q + 1'b1;
        state_d = mrfs_pkg::StAmRd;
      end
      mrfs_pkg::StAmDec: begin
        over_d = 1'b1;
        if (area_new > min_area_q) begin
          i_d     = (mrfs_pkg::ScrCntW)'(min_idx_q);
          state_d = mrfs_pkg::StAsRd;
        end else begin
          state_d = mrfs_pkg::StDone;
        end
      end
      mrfs_pkg::StAsRd: begin
        if (i_q == (mrfs_pkg::ScrCntW)'(mrfs_pkg::MaxFree - 1)) begin
          fwe     = 1'b1;
          fwaddr  = i_q[mrfs_pkg::IdxW-1:0];
          fwdata  = sbox_q;
          state_d = mrfs_pkg::StDone;
        end else begin
          fraddr  = i_q[mrfs_pkg::IdxW-1:0] + 1'b1;
          state_d = mrfs_pkg::StAsWr;
        end
      end
      mrfs_pkg::StAsWr: begin
        fwe     = 1'b1;
        fwaddr  = i_q[mrfs_pkg::IdxW-1:0];
        fwdata  = frd_q;
        i_d     = i_q + 1'b1;
        state_d = mrfs_pkg::StAsRd;
      end

      mrfs_pkg::StOcRd: begin
        fraddr = i_q[mrfs_pkg::IdxW-1:0];
        if (i_q >= (mrfs_pkg::ScrCntW)'(cnt_q)) begin
          state_d = mrfs_pkg::StSoStart;
        end else begin
          state_d = mrfs_pkg::StOcLd;
        end
      end
      mrfs_pkg::StOcLd: begin
        fbox_d  = frd_q;
        ovl_d   = ovl;
        piece_d = '0;
        state_d = mrfs_pkg::StOcPc;
      end
      mrfs_pkg::StOcPc: begin
        if (keep_pc) begin
          swe    = 1'b1;
          swaddr = n_q[mrfs_pkg::ScrIdxW-1:0];
          swdata = '{box: '{x: pxs[CW-1:0], y: pys[CW-1:0], w: pws[CW-1:0],
                            h: phs[CW-1:0]}, area: area_pc};
          n_d    = n_q + 1'b1;
        end
        if (!ovl_q || piece_q == 2'd3) begin
          i_d     = i_q + 1'b1;
          state_d = mrfs_pkg::StOcRd;
        end else begin
          piece_d = piece_q + 1'b1;
        end
      end

      mrfs_pkg::StSoStart: begin
        i_d     = (mrfs_pkg::ScrCntW)'(1);
        state_d = mrfs_pkg::StSoI;
      end
      mrfs_pkg::StSoI: begin
        sraddr = i_q[mrfs_pkg::ScrIdxW-1:0];
        if (i_q >= n_q) begin
          state_d = mrfs_pkg::StPrStart;
        end else begin
          state_d = mrfs_pkg::StSoT;
        end
      end
      mrfs_pkg::StSoT: begin
        t_d     = srd_q;
        k_d     = i_q;
        state_d = mrfs_pkg::StSoK;
      end
      mrfs_pkg::StSoK: begin
        if (k_q == '0) begin
          swe     = 1'b1;
          swaddr  = '0;
          swdata  = t_q;
          i_d     = i_q + 1'b1;
          state_d = mrfs_pkg::StSoI;
        end else begin
          sraddr  = k_q[mrfs_pkg::ScrIdxW-1:0] - 1'b1;
          state_d = mrfs_pkg::StSoC;
        end
      end
      mrfs_pkg::StSoC: begin
        swe    = 1'b1;
        swaddr = k_q[mrfs_pkg::ScrIdxW-1:0];
        if (srd_q.area < t_q.area) begin
          swdata  = srd_q;
          k_d     = k_q - 1'b1;
          state_d = mrfs_pkg::StSoK;
        end else begin
          swdata  = t_q;
          i_d     = i_q + 1'b1;
          state_d = mrfs_pkg::StSoI;
        end
      end

      mrfs_pkg::StPrStart: begin
        cnt_d   = '0;
        i_d     = '0;
        state_d = mrfs_pkg::StPrI;
      end
      mrfs_pkg::StPrI: begin
        sraddr = i_q[mrfs_pkg::ScrIdxW-1:0];
        if (i_q >= n_q) begin
          state_d = mrfs_pkg::StDone;
        end else begin
          state_d = mrfs_pkg::StPrT;
        end
      end
      mrfs_pkg::StPrT: begin
        t_d     = srd_q;
        k_d     = '0;
        state_d = mrfs_pkg::StPrK;
      end
      mrfs_pkg::StPrK: begin
        fraddr = k_q[mrfs_pkg::IdxW-1:0];
        if (k_q >= (mrfs_pkg::ScrCntW)'(cnt_q)) begin
          if (cnt_q >= (mrfs_pkg::CntW)'(mrfs_pkg::MaxFree)) begin
            over_d  = 1'b1;
            state_d = mrfs_pkg::StDone;
          end else begin
            fwe     = 1'b1;
            fwaddr  = cnt_q[mrfs_pkg::IdxW-1:0];
            fwdata  = t_q.box;
            cnt_d   = cnt_q + 1'b1;
            i_d     = i_q + 1'b1;
            state_d = mrfs_pkg::StPrI;
          end
        end else begin
          state_d = mrfs_pkg::StPrC;
        end
      end
      mrfs_pkg::StPrC: begin
        if (holds) begin
          i_d     = i_q + 1'b1;
          state_d = mrfs_pkg::StPrI;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = mrfs_pkg::StPrK;
        end
      end

      mrfs_pkg::StDone: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          of_d    = found_q;
          opx_d   = px_q;
          opy_d   = py_q;
          ocnt_d  = cnt_q;
          oov_d   = over_q;
          state_d = mrfs_pkg::StIdle;
        end
      end

      default: state_d = mrfs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrfs_pkg::StIdle;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sbox_q     <= sbox_d;
    fbox_q     <= fbox_d;
    t_q        <= t_d;
    i_q        <= i_d;
    k_q        <= k_d;
    n_q        <= n_d;
    min_idx_q  <= min_idx_d;
    min_area_q <= min_area_d;
    best_q     <= best_d;
    piece_q    <= piece_d;
    ovl_q      <= ovl_d;
    found_q    <= found_d;
    over_q     <= over_d;
    px_q       <= px_d;
    py_q       <= py_d;
    of_q       <= of_d;
    opx_q      <= opx_d;
    opy_q      <= opy_d;
    ocnt_q     <= ocnt_d;
    oov_q      <= oov_d;
  end

  assign out_valid_o  = ov_q;
  assign found_o      = of_q;
  assign place_x_o    = opx_q;
  assign place_y_o    = opy_q;
  assign free_count_o = ocnt_q;
  assign overflow_o   = oov_q;

endmodule

// ----- verif/tb_maxrects_free_space_store.sv -----
// Self-checking testbench for the maximal-rectangles free-space store.
module tb_maxrects_free_space_store;

  localparam longint LimitCycles = 50000000;

  typedef struct {
    longint x, y, w, h;
  } rect_t;

  typedef struct packed {
    logic        found;
    logic [15:0] px;
    logic [15:0] py;
    logic [6:0]  cnt;
    logic        ovf;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [15:0] rect_x_i = '0;
  logic [15:0] rect_y_i = '0;
  logic [15:0] rect_width_i = '0;
  logic [15:0] rect_height_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        found_o;
  logic [15:0] place_x_o;
  logic [15:0] place_y_o;
  logic [6:0]  free_count_o;
  logic        overflow_o;

  maxrects_free_space_store u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .rect_x_i, .rect_y_i,
    .rect_width_i, .rect_height_i, .out_valid_o, .out_ready_i, .found_o,
    .place_x_o, .place_y_o, .free_count_o, .overflow_o
  );

  always #4 clk_i = ~clk_i;

  rect_t   held[$];
  answer_t pending_answers[$];
  int      errors = 0;
  int      n_items = 0;
  int      n_checked = 0;
  int      n_overflows = 0;
  int      n_found = 0;
  bit      sender_idles = 1'b1;
  bit      receiver_idles = 1'b1;
  int      hold_off = 0;
  longint  cycles = 0;

  function automatic longint area_of(rect_t r);
    return r.w * r.h;
  endfunction

  function automatic bit overlaps(rect_t a, rect_t b);
    return a.x < b.x + b.w && b.x < a.x + a.w && a.y < b.y + b.h && b.y < a.y + a.h;
  endfunction

  function automatic bit holds(rect_t o, rect_t i);
    return o.x <= i.x && o.y <= i.y && i.x + i.w <= o.x + o.w &&
           i.y + i.h <= o.y + o.h;
  endfunction

  function automatic void push_piece(ref rect_t pieces[$], input longint x, y, w, h);
    rect_t p;
    if (w <= 0 || h <= 0 || x < 0 || y < 0 || x > 65535 || y > 65535) return;
    if (pieces.size() >= mrfs_pkg::ScrDepth) return;
    p.x = x; p.y = y; p.w = w; p.h = h;
    pieces = {pieces, p};
  endfunction

  function automatic answer_t predict_answer(mrfs_pkg::cmd_e cmd, rect_t b);
    answer_t a;
    rect_t   pieces[$];
    rect_t   t, f;
    longint  best;
    int      k, low;
    bit      keep;
    a = '0;
    case (cmd)
      mrfs_pkg::CmdClear: held.delete();
      mrfs_pkg::CmdAdd: begin
        if (held.size() < mrfs_pkg::MaxFree) begin
          held = {held, b};
        end else begin
          a.ovf = 1'b1;
          low = 0;
          for (int i = 1; i < mrfs_pkg::MaxFree; i++)
            if (area_of(held[i]) < area_of(held[low])) low = i;
          if (area_of(b) > area_of(held[low])) begin
            held.delete(low);
            held = {held, b};
          end
        end
      end
      mrfs_pkg::CmdOccupy: begin
        foreach (held[i]) begin
          f = held[i];
          if (overlaps(f, b)) begin
            push_piece(pieces, f.x, f.y, b.x - f.x, f.h);
            push_piece(pieces, f.x, f.y, f.w, b.y - f.y);
            push_piece(pieces, b.x + b.w, f.y, f.x + f.w - b.x - b.w, f.h);
            push_piece(pieces, f.x, b.y + b.h, f.w, f.y + f.h - b.y - b.h);
          end else begin
            push_piece(pieces, f.x, f.y, f.w, f.h);
          end
        end
        for (int i = 1; i < pieces.size(); i++) begin
          t = pieces[i];
          k = i;
          while (k > 0 && area_of(pieces[k-1]) < area_of(t)) begin
            pieces[k] = pieces[k-1];
            k--;
          end
          pieces[k] = t;
        end
        held.delete();
        foreach (pieces[i]) begin
          keep = 1'b1;
          foreach (held[j]) if (holds(held[j], pieces[i])) keep = 1'b0;
          if (keep) begin
            if (held.size() >= mrfs_pkg::MaxFree) begin
              a.ovf = 1'b1;
              break;
            end
            held = {held, pieces[i]};
          end
        end
      end
      default: begin
        best = 1000000000;
        foreach (held[i]) begin
          if (held[i].w >= b.w && held[i].h >= b.h &&
              (held[i].w - b.w) + (held[i].h - b.h) < best) begin
            best = (held[i].w - b.w) + (held[i].h - b.h);
            a.px = held[i].x[15:0];
            a.py = held[i].y[15:0];
            a.found = 1'b1;
          end
        end
      end
    endcase
    a.cnt = 7'(held.size());
    return a;
  endfunction

  task automatic send_item(mrfs_pkg::cmd_e cmd, int x, int y, int w, int h);
    rect_t   b;
    answer_t exp_a;
    if (sender_idles && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while (sender_idles && $urandom_range(99) < 37) @(negedge clk_i);
    end
    b.x = x[15:0]; b.y = y[15:0]; b.w = w[15:0]; b.h = h[15:0];
    cmd_i <= cmd;
    rect_x_i <= x[15:0];
    rect_y_i <= y[15:0];
    rect_width_i <= w[15:0];
    rect_height_i <= h[15:0];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_a = predict_answer(cmd, b);
    pending_answers = {pending_answers, exp_a};
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_item(mrfs_pkg::CmdFind, 0, 0, 0, 0);
    send_item(mrfs_pkg::CmdAdd, 0, 0, 65535, 65535);
    send_item(mrfs_pkg::CmdFind, 0, 0, 65535, 65535);
    send_item(mrfs_pkg::CmdOccupy, 100, 200, 0, 0);
    send_item(mrfs_pkg::CmdFind, 0, 0, 10, 10);
    send_item(mrfs_pkg::CmdOccupy, 65535, 65535, 65535, 65535);
    send_item(mrfs_pkg::CmdOccupy, 0, 0, 65535, 65535);
    send_item(mrfs_pkg::CmdAdd, 5, 5, 0, 0);
    send_item(mrfs_pkg::CmdFind, 0, 0, 0, 0);
    send_item(mrfs_pkg::CmdFind, 0, 0, 1, 1);
    send_item(mrfs_pkg::CmdClear, 65535, 65535, 65535, 65535);
    send_item(mrfs_pkg::CmdAdd, 0, 0, 100, 100);
    send_item(mrfs_pkg::CmdAdd, 50, 50, 100, 100);
    send_item(mrfs_pkg::CmdOccupy, 40, 40, 20, 20);
    send_item(mrfs_pkg::CmdFind, 1, 1, 30, 30);
    send_item(mrfs_pkg::CmdFind, 0, 0, 200, 200);
    wait_drained();
  endtask

  task automatic test_add_when_full();
    send_item(mrfs_pkg::CmdClear, 0, 0, 0, 0);
    for (int i = 0; i < mrfs_pkg::MaxFree + 4; i++)
      send_item(mrfs_pkg::CmdAdd, $urandom, $urandom, $urandom_range(1, 40),
                $urandom_range(1, 40));
    send_item(mrfs_pkg::CmdAdd, 1, 1, 0, 0);
    send_item(mrfs_pkg::CmdAdd, 1, 1, 1000, 1000);
    send_item(mrfs_pkg::CmdOccupy, 0, 0, 32768, 32768);
    send_item(mrfs_pkg::CmdFind, 0, 0, 2, 2);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int c, s;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(99);
      s = ($urandom_range(9) == 0) ? 65535 : 600;
      if (c < 3)
        send_item(mrfs_pkg::CmdClear, $urandom, $urandom, $urandom, $urandom);
      else if (c < 35)
        send_item(mrfs_pkg::CmdAdd, $urandom_range(0, s), $urandom_range(0, s),
                  $urandom_range(0, s), $urandom_range(0, s));
      else if (c < 60)
        send_item(mrfs_pkg::CmdOccupy, $urandom_range(0, s), $urandom_range(0, s),
                  $urandom_range(0, s / 4), $urandom_range(0, s / 4));
      else
        send_item(mrfs_pkg::CmdFind, $urandom, $urandom, $urandom_range(0, s / 3),
                  $urandom_range(0, s / 3));
      if (held.size() > 48 && $urandom_range(3) == 0)
        send_item(mrfs_pkg::CmdClear, 0, 0, 0, 0);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 12; i++)
      send_item(mrfs_pkg::CmdAdd, $urandom_range(0, 300), $urandom_range(0, 300), 20, 20);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result item", $time);
        errors++;
      end else begin
        answer_t e;
        e = pending_answers.pop_front();
        n_checked++;
        if (e.ovf) n_overflows++;
        if (e.found) n_found++;
        if (found_o !== e.found || place_x_o !== e.px || place_y_o !== e.py ||
            free_count_o !== e.cnt || overflow_o !== e.ovf) begin
          $display("%0t: expected found=%0d x=%0d y=%0d count=%0d ovf=%0d",
                   $time, e.found, e.px, e.py, e.cnt, e.ovf);
          $display("%0t: actual   found=%0d x=%0d y=%0d count=%0d ovf=%0d",
                   $time, found_o, place_x_o, place_y_o, free_count_o, overflow_o);
          errors++;
        end
      end
    end
    if (cycles > LimitCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready_i <= !(receiver_idles && $urandom_range(99) < 37);
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_add_when_full();
    test_backpressure();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random(150);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    test_random(500);
    wait_drained();
    repeat (50) @(negedge clk_i);
    $display("Sent %0d items, checked %0d results (%0d overflows, %0d fits found).",
             n_items, n_checked, n_overflows, n_found);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mrfs_pkg.sv
sv/maxrects_free_space_store.sv
verif/tb_maxrects_free_space_store.sv
